// ===== rtl/core/flptw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flptw_pkg
// Types and constants for the four-level page table map and walk block.
// ----------------------------------------------------------------------------
package flptw_pkg;

  localparam int TABLE_PAGES_DEF = 16;

  localparam int ADDR_W   = 48;
  localparam int PHYS_W   = 52;
  localparam int FRAME_W  = 40;  // physical address bits 51:12
  localparam int ENTRY_W  = 64;
  localparam int PERM_W   = 30;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 9;

  // request codes
  localparam logic [1:0] REQ_MAP = 2'd0;
  localparam logic [1:0] REQ_FWD = 2'd1;
  localparam logic [1:0] REQ_REV = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_ABSENT  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_POOL    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BIT47   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd4;

  // entry bit positions
  localparam int PTE_PRESENT = 0;
  localparam int PTE_LARGE   = 7;
  localparam int PTE_BIT47   = 47;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LEAF,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/four_level_page_table_map_walk_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_map_walk_top
// Forward and reverse four-level page tables in one table memory, with a
// sequencer that maps pages into both tables and walks either one.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (req_type, guest_addr, host_addr, write_ok, exec_ok) move on
//   in_valid / in_stall; one result word (status, translated_addr, perm_bits)
//   per request moves on out_valid / out_stall. table_base is written with
//   cfg_write / cfg_data while the block is idle.
//   Each level goes through a read state and an evaluate state. A translate
//   walks one to four levels and then passes the finish state; a map walks
//   three levels of each table, forward then reverse, writes each leaf and
//   then finishes, or stops early on a failure. Map requests with bit 47 set
//   in either address and unused request codes finish right after acceptance.
//   The result sits in an output register; the next request is taken the
//   cycle after the result is loaded there, even while out_stall holds it.
//   If the previous result is still stalled, the finished result waits in
//   the sequencer and in_stall stays high.
//   After reset a clearing pass writes zero to every entry, one per cycle;
//   in_stall is high during it.
// ----------------------------------------------------------------------------
module four_level_page_table_map_walk_top #(
  parameter int TABLE_PAGES = flptw_pkg::TABLE_PAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [flptw_pkg::PHYS_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [1:0]                    req_type,
  input  wire logic [flptw_pkg::ADDR_W-1:0]  guest_addr,
  input  wire logic [flptw_pkg::ADDR_W-1:0]  host_addr,
  input  wire logic                          write_ok,
  input  wire logic                          exec_ok,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [flptw_pkg::STATUS_W-1:0] status,
  output      logic [flptw_pkg::PHYS_W-1:0]  translated_addr,
  output      logic [flptw_pkg::PERM_W-1:0]  perm_bits
);
  import flptw_pkg::*;

  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int NW    = $clog2(TABLE_PAGES + 1);
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = TABLE_PAGES * 512;
  localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [NW-1:0]      PAGES_N   = NW'(TABLE_PAGES);
  localparam logic [NW-1:0]      POOL_INIT = NW'(2);
  localparam logic [FRAME_W-1:0] PAGES_F   = FRAME_W'(TABLE_PAGES);

  // table memory
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  state_t state, state_next;
  logic [FRAME_W-1:0]  table_base;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic [1:0]          req, req_next;
  logic [ADDR_W-1:0]   gaddr, gaddr_next;
  logic [ADDR_W-1:0]   haddr, haddr_next;
  logic [ENTRY_W-1:0]  perm, perm_next;
  logic                tbl, tbl_next;
  logic [1:0]          level, level_next;
  logic [PW-1:0]       page, page_next;
  logic [NW-1:0]       nfp, nfp_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [PHYS_W-1:0]   res_addr, res_addr_next;
  logic [PERM_W-1:0]   res_perm, res_perm_next;
  logic                load_out;

  // walk datapath
  logic [ADDR_W-1:0]  cur_addr;
  logic [ADDR_W-1:0]  leaf_frame;
  logic [IDX_W-1:0]   idx;
  logic [FRAME_W-1:0] ptr_diff;
  logic               ptr_inside;
  logic [FRAME_W-1:0] new_frame;
  logic [PHYS_W-1:0]  lo_mask;
  logic [PHYS_W-1:0]  hit_addr;

  assign cur_addr   = tbl ? haddr : gaddr;
  assign leaf_frame = tbl ? gaddr : haddr;

  always_comb begin
    case (level)
      2'd0:    idx = cur_addr[47:39];
      2'd1:    idx = cur_addr[38:30];
      2'd2:    idx = cur_addr[29:21];
      default: idx = cur_addr[20:12];
    endcase
  end

  always_comb begin
    case (level)
      2'd1:    lo_mask = PHYS_W'((64'd1 << 30) - 64'd1);
      2'd2:    lo_mask = PHYS_W'((64'd1 << 21) - 64'd1);
      default: lo_mask = PHYS_W'((64'd1 << 12) - 64'd1);
    endcase
  end

  // pointer frame relative to the store, modulo 2^52
  assign ptr_diff   = mem_rdata[51:12] - table_base;
  assign ptr_inside = ptr_diff < PAGES_F;
  assign new_frame  = table_base + FRAME_W'(nfp);
  assign hit_addr   = ({mem_rdata[51:12], 12'd0} & ~lo_mask)
                    | ({{(PHYS_W-ADDR_W){1'b0}}, cur_addr} & lo_mask);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    req_next        = req;
    gaddr_next      = gaddr;
    haddr_next      = haddr;
    perm_next       = perm;
    tbl_next        = tbl;
    level_next      = level;
    page_next       = page;
    nfp_next        = nfp;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    res_perm_next   = res_perm;
    load_out        = 1'b0;
    mem_we          = 1'b0;
    mem_raddr       = {page, idx};
    mem_waddr       = {page, idx};
    mem_wdata       = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_next        = req_type;
          gaddr_next      = guest_addr;
          haddr_next      = host_addr;
          perm_next       = {!exec_ok, 60'd0, 1'b1, write_ok, 1'b1};
          tbl_next        = (req_type == REQ_REV);
          level_next      = 2'd0;
          page_next       = {{(PW-1){1'b0}}, (req_type == REQ_REV)};
          res_status_next = STAT_OK;
          res_addr_next   = '0;
          res_perm_next   = '0;
          if (req_type == REQ_MAP) begin
            if (guest_addr[47] || host_addr[47]) begin
              res_status_next = STAT_BIT47;
              state_next      = S_FINISH;
            end else begin
              state_next = S_READ;
            end
          end else if (req_type == REQ_FWD || req_type == REQ_REV) begin
            state_next = S_READ;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (req == REQ_MAP) begin
          if (!mem_rdata[PTE_PRESENT]) begin
            if (nfp >= PAGES_N) begin
              res_status_next = STAT_POOL;
              state_next      = S_FINISH;
            end else begin
              // link a fresh pool page at this level
              mem_we     = 1'b1;
              mem_wdata  = {12'd0, new_frame, 12'd0} | perm;
              nfp_next   = nfp + NW'(1);
              page_next  = nfp[PW-1:0];
              level_next = level + 2'd1;
              state_next = (level == 2'd2) ? S_LEAF : S_READ;
            end
          end else if (!ptr_inside) begin
            res_status_next = STAT_OUTSIDE;
            state_next      = S_FINISH;
          end else begin
            page_next  = ptr_diff[PW-1:0];
            level_next = level + 2'd1;
            state_next = (level == 2'd2) ? S_LEAF : S_READ;
          end
        end else begin
          if (!mem_rdata[PTE_PRESENT]) begin
            res_status_next = STAT_ABSENT;
            state_next      = S_FINISH;
          end else if (level == 2'd3 || (level != 2'd0 && mem_rdata[PTE_LARGE])) begin
            if (mem_rdata[PTE_BIT47]) begin
              res_status_next = STAT_BIT47;
            end else begin
              res_status_next = STAT_OK;
              res_addr_next   = hit_addr;
              res_perm_next   = mem_rdata[PERM_W-1:0] & lo_mask[PERM_W-1:0];
            end
            state_next = S_FINISH;
          end else if (!ptr_inside) begin
            res_status_next = STAT_OUTSIDE;
            state_next      = S_FINISH;
          end else begin
            page_next  = ptr_diff[PW-1:0];
            level_next = level + 2'd1;
            state_next = S_READ;
          end
        end
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = {16'd0, leaf_frame[47:12], 12'd0} | perm;
        if (!tbl) begin
          // forward table done, now the reverse one
          tbl_next   = 1'b1;
          page_next  = {{(PW-1){1'b0}}, 1'b1};
          level_next = 2'd0;
          state_next = S_READ;
        end else begin
          res_status_next = STAT_OK;
          state_next      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      nfp        <= POOL_INIT;
      table_base <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      nfp      <= nfp_next;
      if (cfg_write) begin
        table_base <= cfg_data[51:12];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    gaddr      <= gaddr_next;
    haddr      <= haddr_next;
    perm       <= perm_next;
    tbl        <= tbl_next;
    level      <= level_next;
    page       <= page_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    res_perm   <= res_perm_next;
    if (load_out) begin
      status          <= res_status;
      translated_addr <= res_addr;
      perm_bits       <= res_perm;
    end
  end

endmodule

`default_nettype wire

// ===== dv/four_level_page_table_map_walk_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_map_walk_top_tb
// Self-checking bench for the page table map/walk block. Map and translate
// words go in with random gaps and output stalls; a private copy of both
// page tables predicts each result word, and table_base is moved between
// phases so that stale pointers, wrapped offsets and level mixups get hit.
// ----------------------------------------------------------------------------
module four_level_page_table_map_walk_top_tb;
  import flptw_pkg::*;

  localparam int          TABLE_PAGES     = TABLE_PAGES_DEF;
  localparam int          SLOTS           = 512;
  localparam int          CYCLE_LIMIT     = 600000;
  localparam int          TOP_SHIFT       = 39;
  localparam int          LEAF_SHIFT      = 12;
  localparam logic [1:0]  REQ_NONE        = 2'd3;
  localparam int unsigned FWD_ROOT        = 0;
  localparam int unsigned REV_ROOT        = 1;
  localparam int unsigned FIRST_POOL_PAGE = 2;
  localparam logic [63:0] FRAME_MASK      = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] ADDR52_MASK     = 64'h000f_ffff_ffff_ffff;
  localparam logic [63:0] ENT_PRESENT     = 64'h1;
  localparam logic [63:0] ENT_WRITE       = 64'h2;
  localparam logic [63:0] ENT_USER        = 64'h4;
  localparam logic [63:0] ENT_NOEXEC      = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] gaddr;
    logic [ADDR_W-1:0] haddr;
    logic              wr;
    logic              ex;
  } xlat_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [PHYS_W-1:0]   addr;
    logic [PERM_W-1:0]   perm;
  } xlat_resp_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [PHYS_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          req_type = 2'd0;
  logic [ADDR_W-1:0]   guest_addr = '0;
  logic [ADDR_W-1:0]   host_addr = '0;
  logic                write_ok = 1'b0;
  logic                exec_ok = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PHYS_W-1:0]   translated_addr;
  logic [PERM_W-1:0]   perm_bits;

  four_level_page_table_map_walk_top #(
    .TABLE_PAGES(TABLE_PAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .guest_addr(guest_addr),
    .host_addr(host_addr),
    .write_ok(write_ok),
    .exec_ok(exec_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .translated_addr(translated_addr),
    .perm_bits(perm_bits)
  );

  // shadow copy of the table store
  logic [63:0] shadow_tables [TABLE_PAGES*SLOTS];
  int unsigned shadow_next_page;
  logic [63:0] shadow_base;

  xlat_req_t   request_queue[$];
  xlat_resp_t  awaited_responses[$];
  xlat_req_t   on_port;
  xlat_resp_t  want;
  int          gap_left;
  int          stall_left;
  int          idle_pct;
  int          fail_count;
  int          cycle_count;

  logic [ADDR_W-1:0] guest_region [2];
  logic [ADDR_W-1:0] host_region [2];
  logic [ADDR_W-1:0] mapped_guest[$];
  logic [ADDR_W-1:0] mapped_host[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] pool_page_addr(int unsigned pg);
    return (shadow_base + (64'(pg) << 12)) & FRAME_MASK;
  endfunction

  // returns 0 when the entry's frame lies outside the store
  function automatic bit frame_page(logic [63:0] ent, output int unsigned pg);
    logic [63:0] off;
    off = ((ent & FRAME_MASK) - shadow_base) & ADDR52_MASK;
    pg  = 32'(off >> 12);
    return off < (64'(TABLE_PAGES) << 12);
  endfunction

  function automatic int unsigned slot_of(int unsigned pg, logic [63:0] va, int sh);
    return pg * SLOTS + 32'((va >> sh) & 64'h1ff);
  endfunction

  function automatic logic [STATUS_W-1:0] link_path(int unsigned root, logic [63:0] va,
                                                   logic [63:0] frame, logic [63:0] perm);
    int unsigned pg;
    int unsigned s;
    pg = root;
    for (int sh = TOP_SHIFT; sh > LEAF_SHIFT; sh -= 9) begin
      s = slot_of(pg, va, sh);
      if ((shadow_tables[s] & ENT_PRESENT) == 0) begin
        if (shadow_next_page >= TABLE_PAGES) return STAT_POOL;
        shadow_tables[s] = pool_page_addr(shadow_next_page) | perm;
        shadow_next_page++;
      end
      // any present entry is followed as a pointer, large bit or not
      if (!frame_page(shadow_tables[s], pg)) return STAT_OUTSIDE;
    end
    shadow_tables[slot_of(pg, va, LEAF_SHIFT)] = (frame & FRAME_MASK) | perm;
    return STAT_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] walk_table(int unsigned root, logic [63:0] va,
                                                    output logic [PHYS_W-1:0] pa,
                                                    output logic [PERM_W-1:0] pb);
    int unsigned pg;
    logic [63:0] ent;
    logic [63:0] msk;
    pg = root;
    pa = '0;
    pb = '0;
    for (int sh = TOP_SHIFT; sh >= LEAF_SHIFT; sh -= 9) begin
      ent = shadow_tables[slot_of(pg, va, sh)];
      if (!ent[PTE_PRESENT]) return STAT_ABSENT;
      // large bit counts only below the top level
      if (sh == LEAF_SHIFT || (sh < TOP_SHIFT && ent[PTE_LARGE])) begin
        msk = (64'd1 << sh) - 64'd1;
        if (ent[PTE_BIT47]) return STAT_BIT47;
        pa = 52'((ent & FRAME_MASK & ~msk) + (va & msk));
        pb = 30'(ent & msk);
        return STAT_OK;
      end
      if (!frame_page(ent, pg)) return STAT_OUTSIDE;
    end
    return STAT_OK;
  endfunction

  function automatic xlat_resp_t table_response(xlat_req_t rq);
    xlat_resp_t r;
    logic [63:0] perm;
    logic [PHYS_W-1:0] pa;
    logic [PERM_W-1:0] pb;
    r = '0;
    case (rq.kind) inside
      REQ_MAP: begin
        perm = ENT_PRESENT | ENT_USER;
        if (rq.wr) perm |= ENT_WRITE;
        if (!rq.ex) perm |= ENT_NOEXEC;
        if (rq.gaddr[47] || rq.haddr[47]) begin
          r.st = STAT_BIT47;
        end else begin
          // forward first; a failure there leaves the reverse table alone
          r.st = link_path(FWD_ROOT, 64'(rq.gaddr), 64'(rq.haddr), perm);
          if (r.st == STAT_OK) r.st = link_path(REV_ROOT, 64'(rq.haddr), 64'(rq.gaddr), perm);
        end
      end
      REQ_FWD, REQ_REV: begin
        r.st = walk_table(rq.kind == REQ_FWD ? FWD_ROOT : REV_ROOT,
                          64'(rq.kind == REQ_FWD ? rq.gaddr : rq.haddr), pa, pb);
        if (r.st == STAT_OK) begin
          r.addr = pa;
          r.perm = pb;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (fail_count < 40) $display("%0t: %s mismatch, got %h expected %h", $time, what, got,
                                  exp_val);
    fail_count++;
  endtask

  function automatic bit coin();
    return 1'($urandom());
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic put(logic [1:0] k, logic [ADDR_W-1:0] g, logic [ADDR_W-1:0] h,
                     logic wr, logic ex);
    xlat_req_t r;
    r.kind  = k;
    r.gaddr = g;
    r.haddr = h;
    r.wr    = wr;
    r.ex    = ex;
    request_queue.push_back(r);
  endtask

  // mostly maps and translates inside a few fixed regions so the pool lasts
  task automatic queue_random(int n);
    logic [ADDR_W-1:0] g;
    logic [ADDR_W-1:0] h;
    int unsigned pick;
    int unsigned idx;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      g = rand_addr();
      h = rand_addr();
      if (pick < 40) begin
        g = guest_region[coin()] | 48'(g[20:0]);
        h = host_region[coin()] | 48'(h[20:0]);
        mapped_guest.push_back(g);
        mapped_host.push_back(h);
        if (mapped_guest.size() > 32) begin
          void'(mapped_guest.pop_front());
          void'(mapped_host.pop_front());
        end
        put(REQ_MAP, g, h, coin(), coin());
      end else if (pick < 60 && mapped_guest.size() > 0) begin
        idx = $urandom_range(0, mapped_guest.size() - 1);
        put(REQ_FWD, {mapped_guest[idx][47:12], g[11:0]}, h, coin(), coin());
      end else if (pick < 75 && mapped_host.size() > 0) begin
        idx = $urandom_range(0, mapped_host.size() - 1);
        put(REQ_REV, g, {mapped_host[idx][47:12], h[11:0]}, coin(), coin());
      end else if (pick < 85) begin
        g = guest_region[coin()] | 48'(g[20:0]);
        h = host_region[coin()] | 48'(h[20:0]);
        put(pick[0] ? REQ_FWD : REQ_REV, g, h, coin(), coin());
      end else if (pick < 97) begin
        put(2'($urandom_range(0, 3)), g, h, coin(), coin());
      end else begin
        put(REQ_NONE, g, h, coin(), coin());
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_responses.size() != 0);
  endtask

  task automatic write_base(logic [PHYS_W-1:0] v);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_base = 64'(v) & FRAME_MASK;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) awaited_responses.push_back(table_response(on_port));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0 && $urandom_range(1, 100) <= idle_pct) begin
          gap_left = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          on_port = request_queue.pop_front();
          in_valid   <= 1'b1;
          req_type   <= on_port.kind;
          guest_addr <= on_port.gaddr;
          host_addr  <= on_port.haddr;
          write_ok   <= on_port.wr;
          exec_ok    <= on_port.ex;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch("unexpected word", 64'(status), 64'd0);
        end else begin
          want = awaited_responses.pop_front();
          if (status !== want.st) report_mismatch("status", 64'(status), 64'(want.st));
          if (translated_addr !== want.addr)
            report_mismatch("translated_addr", 64'(translated_addr), 64'(want.addr));
          if (perm_bits !== want.perm)
            report_mismatch("perm_bits", 64'(perm_bits), 64'(want.perm));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(1, 300) <= idle_pct) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[four_level_page_table_map_walk_top] ERROR");
      $finish;
    end
  end

  initial begin
    logic [PHYS_W-1:0] base_a;
    logic [PHYS_W-1:0] base_shifted;
    foreach (shadow_tables[i]) shadow_tables[i] = '0;
    shadow_next_page = FIRST_POOL_PAGE;
    shadow_base = '0;
    fail_count = 0;
    cycle_count = 0;
    idle_pct = 12;
    guest_region[0] = rand_addr() & 48'h7fff_ffe0_0000;
    guest_region[1] = guest_region[0];
    guest_region[1][29:21] = guest_region[0][29:21] ^ 9'($urandom_range(1, 511));
    host_region[0] = rand_addr() & 48'h7fff_ffe0_0000;
    host_region[1] = host_region[0];
    host_region[1][29:21] = host_region[0][29:21] ^ 9'($urandom_range(1, 511));
    // bit 47 in the base puts bit 47 into every pointer entry
    base_a = 52'({$urandom(), $urandom()});
    base_a[47] = 1'b1;
    base_shifted = 52'((base_a & 52'hf_ffff_ffff_f000) + 52'h1000)
                   | 52'($urandom_range(0, 4095));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_base(base_a);
    @(negedge clk);

    put(REQ_FWD, 48'h0, 48'h0, 1'b0, 1'b0);
    put(REQ_REV, '1, '1, 1'b1, 1'b1);
    put(REQ_MAP, guest_region[0], host_region[0], 1'b1, 1'b1);
    put(REQ_MAP, guest_region[0] | 48'h1000, host_region[0] | 48'h1000, 1'b0, 1'b0);
    put(REQ_MAP, guest_region[1] | 48'h1f_f000, host_region[1] | 48'h1f_f000, 1'b1, 1'b0);
    put(REQ_FWD, guest_region[0] | 48'hfff, 48'h0, 1'b0, 1'b0);
    put(REQ_REV, 48'h0, host_region[0] | 48'h1abc, 1'b0, 1'b0);
    put(REQ_FWD, guest_region[1] | 48'h1f_f123, 48'h0, 1'b1, 1'b0);
    put(REQ_REV, 48'h0, host_region[1] | 48'h1f_fffe, 1'b0, 1'b1);
    put(REQ_FWD, guest_region[0] | 48'h2000, 48'h0, 1'b0, 1'b0);
    put(REQ_MAP, 48'h8000_0000_0000, host_region[0], 1'b1, 1'b1);
    put(REQ_MAP, guest_region[0], 48'hffff_ffff_ffff, 1'b1, 1'b1);
    put(REQ_NONE, '1, '1, 1'b1, 1'b1);
    // fresh paths at both ends of the address space use up the pool
    put(REQ_MAP, 48'h7fff_ffff_ffff, 48'h0, 1'b1, 1'b1);
    put(REQ_FWD, 48'h7fff_ffff_ffff, 48'h0, 1'b0, 1'b0);
    put(REQ_REV, 48'h0, 48'h0, 1'b0, 1'b0);
    // forward leaf lands, reverse runs out of pool pages
    put(REQ_MAP, guest_region[0] | 48'h5000, host_region[0] ^ 48'h4000_0000_0000, 1'b0, 1'b1);
    put(REQ_FWD, guest_region[0] | 48'h5abc, 48'h0, 1'b0, 1'b0);
    put(REQ_MAP, 48'h0, 48'h7fff_ffff_f000, 1'b0, 1'b1);
    put(REQ_MAP, guest_region[0], host_region[1] | 48'h3000, 1'b0, 1'b1);
    put(REQ_FWD, guest_region[0] | 48'h0ff, 48'h0, 1'b0, 1'b0);
    put(REQ_REV, 48'h0, '1, 1'b0, 1'b0);
    queue_random(600);

    // hold the sender until the pipe is empty
    wait_drained();
    idle_pct = 3;
    queue_random(500);

    wait_drained();
    write_base('1);
    @(negedge clk);
    idle_pct = 25;
    queue_random(200);

    wait_drained();
    write_base('0);
    @(negedge clk);
    idle_pct = 0;
    queue_random(200);

    wait_drained();
    write_base(base_shifted);
    @(negedge clk);
    idle_pct = 12;
    queue_random(200);

    wait_drained();
    write_base(base_a);
    @(negedge clk);
    idle_pct = 0;
    queue_random(300);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[four_level_page_table_map_walk_top] OK");
    end else begin
      $display("[four_level_page_table_map_walk_top] ERROR");
    end
    $finish;
  end

endmodule
